[rtl/core/mst_pkg.sv]
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and codes for the minimum spanning tree engine.
// ----------------------------------------------------------------------------
package mst_pkg;

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_ADD_UNDIR = 2'd0;
	localparam opcode_t OP_ADD_DIR   = 2'd1;
	localparam opcode_t OP_RUN       = 2'd2;
	localparam opcode_t OP_CLEAR     = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_E_RD,
		ST_E_WR,
		ST_INIT,
		ST_JOIN,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} mst_state_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic init;
		logic add_vtx;
	} cell_ctl_t;

endpackage

[rtl/core/mst_mem.sv]
// ----------------------------------------------------------------------------
// mst_mem
// Edge weight matrix: one write port, one registered read port, and a
// valid bit per entry so that an unwritten or cleared entry reads as no edge.
// ----------------------------------------------------------------------------
module mst_mem #(
	parameter int AW = 8,
	parameter int WB = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [WB-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WB-1:0] rdata_q,
	output logic          rvld_q
);

	localparam int Depth = 1 << AW;

	logic [WB-1:0]    mem_q [Depth];
	logic [Depth-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr];
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

[rtl/core/mst_cell.sv]
// ----------------------------------------------------------------------------
// mst_cell
// One vertex of the tree search: holds visited flag, best edge length and
// its parent, folds in the matrix word for its vertex and passes the running
// minimum candidate on to the next cell.
// ----------------------------------------------------------------------------
module mst_cell #(
	parameter int IDX = 0,
	parameter int VW  = 4,
	parameter int WB  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mst_pkg::cell_ctl_t ctl,
	input  logic [VW-1:0]     cur,
	input  logic              live,
	input  logic              active,
	input  logic [WB-1:0]     w,
	input  logic              tin_found,
	input  logic [WB-1:0]     tin_low,
	input  logic [VW-1:0]     tin_pick,
	input  logic [VW-1:0]     tin_par,
	output logic              tout_found_q,
	output logic [WB-1:0]     tout_low_q,
	output logic [VW-1:0]     tout_pick_q,
	output logic [VW-1:0]     tout_par_q
);

	localparam logic [VW-1:0] IdxV = VW'(IDX);

	logic          vis_q;
	logic [WB-1:0] best_q;
	logic [VW-1:0] par_q;
	logic          open_w;
	logic          upd;
	logic [WB-1:0] best_n;
	logic [VW-1:0] par_n;
	logic          cand;

	assign open_w = active && live && !vis_q;
	assign upd    = open_w && (w < best_q);
	assign best_n = upd ? w : best_q;
	assign par_n  = upd ? cur : par_q;
	assign cand   = open_w && (best_n < tin_low);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q        <= 1'b0;
			best_q       <= '1;
			par_q        <= '0;
			tout_found_q <= 1'b0;
		end else begin
			if (ctl.init) begin
				vis_q  <= 1'b0;
				best_q <= '1;
				par_q  <= '0;
			end else begin
				if (ctl.add_vtx && cur == IdxV) begin
					vis_q <= 1'b1;
				end
				if (upd) begin
					best_q <= w;
					par_q  <= cur;
				end
			end
			if (active) begin
				tout_found_q <= cand ? 1'b1 : tin_found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			tout_low_q  <= cand ? best_n : tin_low;
			tout_pick_q <= cand ? IdxV : tin_pick;
			tout_par_q  <= cand ? par_n : tin_par;
		end
	end

endmodule

[rtl/core/prim_minimum_spanning_tree_core.sv]
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// Prim minimum spanning tree engine over a stored weight matrix, with a
// chain of per-vertex cells doing the relax and minimum search.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   opcode, vertex_a, vertex_b, weight
//  out      output     out_valid / out_stall parent_vertex, child_vertex,
//                                            edge_weight, disconnected, last
//  cfg      input      cfg_wr_en             cfg_wr_data (vertex count)
//
// Add edge: read-modify-write on the matrix, once directed and once in each
// direction undirected. Clear drops every matrix valid bit. Run: per joined
// vertex, one matrix read per cell as the candidate moves down the cell chain.
// Reset clears the matrix valid bits, so no clearing pass is needed.
// Output stall holds the result register; the next result waits behind it.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]    cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic [$clog2(MAX_VERTICES)-1:0]      vertex_a,
	input  logic [$clog2(MAX_VERTICES)-1:0]      vertex_b,
	input  logic [WEIGHT_BITS-1:0]               weight,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [$clog2(MAX_VERTICES)-1:0]      parent_vertex,
	output logic [$clog2(MAX_VERTICES)-1:0]      child_vertex,
	output logic [WEIGHT_BITS-1:0]               edge_weight,
	output logic                                 disconnected,
	output logic                                 last
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int WB = WEIGHT_BITS;
	localparam int AW = 2 * VW;
	localparam int CntReset = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
	localparam logic [VW-1:0] LastIdx = VW'(MAX_VERTICES - 1);

	mst_pkg::mst_state_t state_q, state_d;
	mst_pkg::cell_ctl_t  ctl;

	logic [CW-1:0] vc_q;
	logic [CW-1:0] n_w;
	logic          in_acc;
	logic          ld_ok;
	logic          a_ok, b_ok, bad_start;
	logic          is_last;
	logic          cont;

	logic [VW-1:0] ea_q, eb_q, cur_q, step_q;
	logic [WB-1:0] ew_q;
	logic          dual_q, err_q;
	logic [CW-1:0] joined_q;

	logic          rd_v_s1;
	logic [VW-1:0] rd_idx_s1;
	logic          end_v_q;

	logic [AW-1:0] raddr;
	logic [WB-1:0] rdata_q;
	logic          rvld_q;
	logic [WB-1:0] w_s1;
	logic          mem_we, mem_clr;

	logic                 tf [MAX_VERTICES+1];
	logic [WB-1:0]        tl [MAX_VERTICES+1];
	logic [VW-1:0]        tp [MAX_VERTICES+1];
	logic [VW-1:0]        tpar [MAX_VERTICES+1];
	logic [MAX_VERTICES-1:0] live, active;

	logic          out_valid_q, disc_q, last_q;
	logic [VW-1:0] par_out_q, chi_out_q;
	logic [WB-1:0] wt_out_q;

	assign n_w = (vc_q == '0) ? CW'(1) :
		((vc_q > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_q);

	assign in_stall  = (state_q != mst_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign ld_ok     = !out_valid_q || !out_stall;
	assign a_ok      = CW'(vertex_a) < n_w;
	assign b_ok      = CW'(vertex_b) < n_w;
	assign bad_start = CW'(cur_q) >= n_w;
	assign is_last   = ({1'b0, joined_q} + (CW+1)'(1)) >= {1'b0, n_w};
	assign cont      = !err_q && tf[MAX_VERTICES] && !is_last;
	assign w_s1      = rvld_q ? rdata_q : '1;

	assign mem_clr = in_acc && (opcode == mst_pkg::OP_CLEAR);
	assign mem_we  = (state_q == mst_pkg::ST_E_WR) && (ew_q < w_s1);
	assign raddr   = (state_q == mst_pkg::ST_SCAN) ? {cur_q, step_q} : {ea_q, eb_q};

	assign ctl.init    = (state_q == mst_pkg::ST_INIT);
	assign ctl.add_vtx = (state_q == mst_pkg::ST_JOIN);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mst_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (opcode)
						mst_pkg::OP_ADD_UNDIR, mst_pkg::OP_ADD_DIR: begin
							if (a_ok && b_ok) state_d = mst_pkg::ST_E_RD;
						end
						mst_pkg::OP_RUN: state_d = mst_pkg::ST_INIT;
						default: state_d = mst_pkg::ST_IDLE;
					endcase
				end
			end
			mst_pkg::ST_E_RD: state_d = mst_pkg::ST_E_WR;
			mst_pkg::ST_E_WR: state_d = dual_q ? mst_pkg::ST_E_RD : mst_pkg::ST_IDLE;
			mst_pkg::ST_INIT: state_d = bad_start ? mst_pkg::ST_EMIT : mst_pkg::ST_JOIN;
			mst_pkg::ST_JOIN: state_d = (joined_q >= n_w) ? mst_pkg::ST_IDLE : mst_pkg::ST_SCAN;
			mst_pkg::ST_SCAN: begin
				if (step_q == LastIdx) state_d = mst_pkg::ST_DRAIN;
			end
			mst_pkg::ST_DRAIN: begin
				if (end_v_q) state_d = mst_pkg::ST_EMIT;
			end
			mst_pkg::ST_EMIT: begin
				if (ld_ok) state_d = cont ? mst_pkg::ST_JOIN : mst_pkg::ST_IDLE;
			end
			default: state_d = mst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mst_pkg::ST_IDLE;
			vc_q        <= CW'(CntReset);
			dual_q      <= 1'b0;
			err_q       <= 1'b0;
			joined_q    <= '0;
			step_q      <= '0;
			rd_v_s1     <= 1'b0;
			end_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == mst_pkg::ST_SCAN);
			end_v_q <= active[MAX_VERTICES-1];
			if (cfg_wr_en) vc_q <= cfg_wr_data;
			if (in_acc) begin
				dual_q   <= (opcode == mst_pkg::OP_ADD_UNDIR);
				joined_q <= CW'(1);
			end
			if (state_q == mst_pkg::ST_E_WR) dual_q <= 1'b0;
			if (state_q == mst_pkg::ST_INIT) err_q <= bad_start;
			if (state_q == mst_pkg::ST_JOIN) step_q <= '0;
			if (state_q == mst_pkg::ST_SCAN) step_q <= step_q + VW'(1);
			if (state_q == mst_pkg::ST_EMIT && ld_ok) begin
				out_valid_q <= 1'b1;
				if (cont) joined_q <= joined_q + CW'(1);
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= step_q;
		if (in_acc) begin
			ea_q  <= vertex_a;
			eb_q  <= vertex_b;
			ew_q  <= weight;
			cur_q <= vertex_a;
		end
		if (state_q == mst_pkg::ST_E_WR) begin
			ea_q <= eb_q;
			eb_q <= ea_q;
		end
		if (state_q == mst_pkg::ST_EMIT && ld_ok) begin
			if (cont) cur_q <= tp[MAX_VERTICES];
			if (err_q || !tf[MAX_VERTICES]) begin
				par_out_q <= '0;
				chi_out_q <= '0;
				wt_out_q  <= '0;
				disc_q    <= 1'b1;
				last_q    <= 1'b1;
			end else begin
				par_out_q <= tpar[MAX_VERTICES];
				chi_out_q <= tp[MAX_VERTICES];
				wt_out_q  <= tl[MAX_VERTICES];
				disc_q    <= 1'b0;
				last_q    <= is_last;
			end
		end
	end

	mst_mem #(
		.AW(AW),
		.WB(WB)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.we     (mem_we),
		.waddr  ({ea_q, eb_q}),
		.wdata  (ew_q),
		.raddr  (raddr),
		.rdata_q(rdata_q),
		.rvld_q (rvld_q)
	);

	assign tf[0]   = 1'b0;
	assign tl[0]   = '1;
	assign tp[0]   = '0;
	assign tpar[0] = '0;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		assign live[g]   = n_w > CW'(g);
		assign active[g] = rd_v_s1 && (rd_idx_s1 == VW'(g));

		mst_cell #(
			.IDX(g),
			.VW (VW),
			.WB (WB)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cur         (cur_q),
			.live        (live[g]),
			.active      (active[g]),
			.w           (w_s1),
			.tin_found   (tf[g]),
			.tin_low     (tl[g]),
			.tin_pick    (tp[g]),
			.tin_par     (tpar[g]),
			.tout_found_q(tf[g+1]),
			.tout_low_q  (tl[g+1]),
			.tout_pick_q (tp[g+1]),
			.tout_par_q  (tpar[g+1])
		);
	end

	assign out_valid     = out_valid_q;
	assign parent_vertex = par_out_q;
	assign child_vertex  = chi_out_q;
	assign edge_weight   = wt_out_q;
	assign disconnected  = disc_q;
	assign last          = last_q;

`ifndef SYNTH
	a_one_active: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(active))
		else $error("more than one cell active");

	a_end_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		end_v_q |-> state_q == mst_pkg::ST_DRAIN)
		else $error("chain end outside drain");

	a_scan_flow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mst_pkg::ST_SCAN |=>
			state_q == mst_pkg::ST_SCAN || state_q == mst_pkg::ST_DRAIN)
		else $error("scan left early");

	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> state_q != mst_pkg::ST_IDLE)
		else $error("run ended without last result");
`endif

endmodule

[tb/prim_minimum_spanning_tree_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_core_tb
// Self-checking bench for the Prim spanning tree engine. A behavioral model
// of the weight matrix and the tree search predicts every result; directed
// cases, random graphs under random idling and a long output hold-off
// are run.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_core_tb;

	localparam int NV = 16;
	localparam logic [15:0] NO_EDGE = 16'hFFFF;

	typedef struct packed {
		logic [3:0]  parent;
		logic [3:0]  child;
		logic [15:0] wt;
		logic        disc;
		logic        fin;
	} tree_edge_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [3:0]  vertex_a;
	logic [3:0]  vertex_b;
	logic [15:0] weight;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  parent_vertex;
	logic [3:0]  child_vertex;
	logic [15:0] edge_weight;
	logic        disconnected;
	logic        last;

	logic [15:0] weight_mat [NV][NV];
	logic [4:0]  vcount;
	tree_edge_t  tree_q [$];

	int send_idle;
	int recv_idle;
	int hold_left;
	int errors;
	int n_items;
	int n_runs;
	int n_edges_seen;

	prim_minimum_spanning_tree_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.weight        (weight),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parent_vertex (parent_vertex),
		.child_vertex  (child_vertex),
		.edge_weight   (edge_weight),
		.disconnected  (disconnected),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("prim_minimum_spanning_tree_core regression: fail");
		$finish;
	end

	function automatic int live_count();
		if (vcount == 0)
			return 1;
		if (vcount > NV)
			return NV;
		return vcount;
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < NV; i++)
			for (int j = 0; j < NV; j++)
				weight_mat[i][j] = NO_EDGE;
	endfunction

	function automatic void push_tree_edge(int p, int c, logic [15:0] w, bit d, bit f);
		tree_edge_t e;
		e.parent = p[3:0];
		e.child = c[3:0];
		e.wt = w;
		e.disc = d;
		e.fin = f;
		tree_q = {tree_q, e};
	endfunction

	function automatic void grow_tree(int start);
		int n;
		int cur;
		int pick;
		bit found;
		logic [15:0] low;
		logic [15:0] best_len [NV];
		int best_par [NV];
		bit in_tree [NV];
		n = live_count();
		n_runs++;
		for (int i = 0; i < NV; i++) begin
			best_len[i] = NO_EDGE;
			best_par[i] = 0;
			in_tree[i] = 0;
		end
		if (start >= n) begin
			push_tree_edge(0, 0, 16'd0, 1, 1);
			return;
		end
		cur = start;
		for (int joined = 1; ; joined++) begin
			in_tree[cur] = 1;
			if (joined >= n)
				break;
			for (int i = 0; i < n; i++)
				if (!in_tree[i] && weight_mat[cur][i] < best_len[i]) begin
					best_len[i] = weight_mat[cur][i];
					best_par[i] = cur;
				end
			found = 0;
			low = NO_EDGE;
			pick = 0;
			for (int i = 0; i < n; i++)
				if (!in_tree[i] && best_len[i] < low) begin
					low = best_len[i];
					pick = i;
					found = 1;
				end
			if (!found) begin
				push_tree_edge(0, 0, 16'd0, 1, 1);
				return;
			end
			push_tree_edge(best_par[pick], pick, low, 0, joined + 1 >= n);
			cur = pick;
		end
	endfunction

	function automatic void predict_item(mst_pkg::opcode_t op, int a, int b, logic [15:0] w);
		int n;
		n = live_count();
		case (op)
			mst_pkg::OP_ADD_UNDIR: begin
				if (a < n && b < n) begin
					if (w < weight_mat[a][b]) weight_mat[a][b] = w;
					if (w < weight_mat[b][a]) weight_mat[b][a] = w;
				end
			end
			mst_pkg::OP_ADD_DIR: begin
				if (a < n && b < n && w < weight_mat[a][b])
					weight_mat[a][b] = w;
			end
			mst_pkg::OP_RUN: grow_tree(a);
			default: clear_graph();
		endcase
	endfunction

	task automatic send_item(mst_pkg::opcode_t op, int a, int b, logic [15:0] w);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		vertex_a <= a[3:0];
		vertex_b <= b[3:0];
		weight <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(op, a, b, w);
		n_items++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tree_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_count(int v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v[4:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vcount = v[4:0];
	endtask

	// output side: random stall, long hold-off on request, compare each transfer
	always @(posedge clk) begin
		tree_edge_t exp_e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (tree_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result p=%0d c=%0d w=%0d d=%0b l=%0b",
							parent_vertex, child_vertex, edge_weight, disconnected, last);
				end else begin
					exp_e = tree_q.pop_front();
					n_edges_seen++;
					if (parent_vertex !== exp_e.parent || child_vertex !== exp_e.child ||
						edge_weight !== exp_e.wt || disconnected !== exp_e.disc ||
						last !== exp_e.fin) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp p=%0d c=%0d w=%0d d=%0b l=%0b got p=%0d c=%0d w=%0d d=%0b l=%0b",
								exp_e.parent, exp_e.child, exp_e.wt, exp_e.disc, exp_e.fin,
								parent_vertex, child_vertex, edge_weight, disconnected, last);
					end
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	task automatic test_directed();
		set_count(16);
		send_item(mst_pkg::OP_CLEAR, 0, 0, 16'd0);
		send_item(mst_pkg::OP_ADD_UNDIR, 0, 15, 16'd0);
		send_item(mst_pkg::OP_ADD_UNDIR, 15, 1, 16'd65534);
		send_item(mst_pkg::OP_ADD_UNDIR, 15, 1, 16'd9);
		send_item(mst_pkg::OP_ADD_UNDIR, 15, 1, 16'd20);
		send_item(mst_pkg::OP_ADD_DIR, 2, 3, 16'hFFFF);
		send_item(mst_pkg::OP_ADD_DIR, 5, 5, 16'd1);
		send_item(mst_pkg::OP_ADD_DIR, 1, 2, 16'd9);
		send_item(mst_pkg::OP_ADD_UNDIR, 15, 3, 16'd9);
		send_item(mst_pkg::OP_RUN, 0, 0, 16'd0);
		send_item(mst_pkg::OP_RUN, 2, 7, 16'd0);
		set_count(4);
		send_item(mst_pkg::OP_ADD_UNDIR, 3, 9, 16'd1);
		send_item(mst_pkg::OP_ADD_UNDIR, 0, 1, 16'd5);
		send_item(mst_pkg::OP_ADD_UNDIR, 1, 2, 16'd5);
		send_item(mst_pkg::OP_ADD_UNDIR, 0, 3, 16'd5);
		send_item(mst_pkg::OP_RUN, 0, 0, 16'd0);
		send_item(mst_pkg::OP_RUN, 9, 0, 16'd0);
		set_count(1);
		send_item(mst_pkg::OP_RUN, 0, 0, 16'd0);
		send_item(mst_pkg::OP_RUN, 1, 0, 16'd0);
		set_count(0);
		send_item(mst_pkg::OP_RUN, 0, 0, 16'd0);
		set_count(31);
		send_item(mst_pkg::OP_RUN, 15, 0, 16'd0);
		set_count(17);
		send_item(mst_pkg::OP_RUN, 4, 0, 16'd0);
		wait_idle();
	endtask

	task automatic random_graph();
		int n;
		int n_adds;
		int a;
		int b;
		logic [15:0] w;
		n = live_count();
		send_item(mst_pkg::OP_CLEAR, $urandom_range(15), $urandom_range(15), 16'($urandom));
		n_adds = $urandom_range(2 * n);
		for (int k = 0; k < n_adds; k++) begin
			a = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
			b = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
			case ($urandom_range(3))
				0: w = 16'($urandom_range(3));
				1: w = 16'($urandom);
				2: w = 16'($urandom_range(65534, 65500));
				default: w = 16'($urandom_range(40));
			endcase
			send_item(mst_pkg::opcode_t'($urandom_range(1)), a, b, w);
		end
		a = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(n - 1);
		send_item(mst_pkg::OP_RUN, a, $urandom_range(15), 16'($urandom));
	endtask

	task automatic test_random_graphs(int s_idle, int r_idle, int target);
		int stop_at;
		send_idle = s_idle;
		recv_idle = r_idle;
		stop_at = n_items + target;
		while (n_items < stop_at) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(3))
					0: set_count(16);
					1: set_count($urandom_range(2));
					2: set_count($urandom_range(31, 17));
					default: set_count($urandom_range(15, 3));
				endcase
			end
			random_graph();
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		set_count(16);
		send_item(mst_pkg::OP_CLEAR, 0, 0, 16'd0);
		for (int i = 0; i < 15; i++)
			send_item(mst_pkg::OP_ADD_UNDIR, i, i + 1, 16'($urandom_range(100)));
		hold_left = 3000;
		for (int k = 0; k < 4; k++)
			send_item(mst_pkg::OP_RUN, $urandom_range(15), 0, 16'd0);
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		opcode = mst_pkg::OP_CLEAR;
		vertex_a = '0;
		vertex_b = '0;
		weight = '0;
		out_stall = 1'b0;
		hold_left = 0;
		send_idle = 0;
		recv_idle = 0;
		errors = 0;
		n_items = 0;
		n_runs = 0;
		n_edges_seen = 0;
		vcount = 5'd16;
		clear_graph();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_graphs(6, 58, 110);
		test_random_graphs(58, 6, 110);
		test_random_graphs(0, 0, 120);
		test_backpressure();
		$display("covered %0d items, %0d tree searches, %0d results checked", n_items,
			n_runs, n_edges_seen);
		$display("counts 0..31, directed and undirected edges, idling on both sides");
		if (errors == 0 && tree_q.size() == 0)
			$display("prim_minimum_spanning_tree_core regression: pass");
		else
			$display("prim_minimum_spanning_tree_core regression: fail");
		$finish;
	end

endmodule
